// File: sv/lcs_pkg.sv
// Package for the clipped LCD fill sequencer: field widths, bus command bytes,
// status, shape and register codes, and the byte-phase enum of the sequencer.
// No dependencies.
package lcs_pkg;

    localparam int DEF_MAX_DIM = 1024;

    localparam int CFG_W     = 11;
    localparam int CFG_IDX_W = 1;
    localparam int POS_W     = 16;
    localparam int COLOR_W   = 16;
    localparam int SHAPE_W   = 3;
    localparam int STATUS_W  = 2;
    localparam int BYTE_W    = 8;

    // signed width that holds x + span - 1 for any 16-bit operands
    localparam int CALC_W = 18;

    localparam logic [CFG_W-1:0] SCREEN_W_RESET = 11'd320;
    localparam logic [CFG_W-1:0] SCREEN_H_RESET = 11'd480;

    localparam logic [BYTE_W-1:0] CMD_COLUMN = 8'h2A;
    localparam logic [BYTE_W-1:0] CMD_PAGE   = 8'h2B;
    localparam logic [BYTE_W-1:0] CMD_WRITE  = 8'h2C;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SCREEN_WIDTH  = 1'b0,
        CFG_SCREEN_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        OP_REQUEST = 1'b0,
        OP_TICK    = 1'b1
    } t_op;

    typedef enum logic [SHAPE_W-1:0] {
        SHAPE_PIXEL = 3'd0,
        SHAPE_HLINE = 3'd1,
        SHAPE_VLINE = 3'd2,
        SHAPE_RECT  = 3'd3,
        SHAPE_FULL  = 3'd4
    } t_shape;

    typedef enum logic [STATUS_W-1:0] {
        ST_BYTE    = 2'd0,
        ST_CLIPPED = 2'd1,
        ST_REFUSED = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        PH_CMD_COL,
        PH_XS_HI,
        PH_XS_LO,
        PH_XE_HI,
        PH_XE_LO,
        PH_CMD_PAGE,
        PH_YS_HI,
        PH_YS_LO,
        PH_YE_HI,
        PH_YE_LO,
        PH_CMD_WRITE,
        PH_DATA
    } t_phase;

endpackage

// File: sv/lcs_req_if.sv
// Request channel of the clipped LCD fill sequencer: valid/ready plus payload.
// Depends on lcs_pkg.
interface lcs_req_if import lcs_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [SHAPE_W-1:0]        shape;
    logic signed [POS_W-1:0]   x_pos;
    logic signed [POS_W-1:0]   y_pos;
    logic signed [POS_W-1:0]   span_x;
    logic signed [POS_W-1:0]   span_y;
    logic [COLOR_W-1:0]        color;

    modport source (output valid, operation, shape, x_pos, y_pos, span_x, span_y, color,
                    input ready);
    modport sink   (input valid, operation, shape, x_pos, y_pos, span_x, span_y, color,
                    output ready);
endinterface

// File: sv/lcs_rsp_if.sv
// Result channel of the clipped LCD fill sequencer: valid/ready plus payload.
// Depends on lcs_pkg.
interface lcs_rsp_if import lcs_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [STATUS_W-1:0]   status;
    logic [BYTE_W-1:0]     bus_byte;
    logic                  is_command;
    logic                  last;

    modport source (output valid, status, bus_byte, is_command, last, input ready);
    modport sink   (input valid, status, bus_byte, is_command, last, output ready);
endinterface

// File: sv/lcd_clipped_fill_sequencer_core.sv
// Clipped rectangle fill sequencer for an 8-bit 8080-style LCD bus.
// A transaction waits in the input register, and its result then in the result register.
// Throughput: one transaction per cycle unless the result port stalls; clip, window
// load and byte select sit between the input register and the result register, the
// pixel count runs as column/row counters. Reset (synchronous, active low) clears the
// sequencer and both registers' valid bits and sets the screen size to 320 x 480.
module lcd_clipped_fill_sequencer_core
    import lcs_pkg::*;
#(
    parameter int MAX_DIM = DEF_MAX_DIM
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    lcs_req_if.sink               i_req,
    lcs_rsp_if.source             o_rsp,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    localparam int CW = $clog2(MAX_DIM);   // window coordinate width
    localparam int DW = CW + 1;            // column/row count width

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] r_screen_w;
    logic [CFG_W-1:0] r_screen_h;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_screen_w <= SCREEN_W_RESET;
            r_screen_h <= SCREEN_H_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_SCREEN_WIDTH:  r_screen_w <= i_cfg_data;
                CFG_SCREEN_HEIGHT: r_screen_h <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- input register ----------------
    logic                     r_in_valid;
    logic                     r_in_op;
    logic [SHAPE_W-1:0]       r_in_shape;
    logic signed [POS_W-1:0]  r_in_x;
    logic signed [POS_W-1:0]  r_in_y;
    logic signed [POS_W-1:0]  r_in_sx;
    logic signed [POS_W-1:0]  r_in_sy;
    logic [COLOR_W-1:0]       r_in_color;

    logic r_out_valid;
    logic w_adv;
    logic w_step;

    assign w_adv       = !r_out_valid || o_rsp.ready;
    assign i_req.ready = !r_in_valid || w_adv;
    assign w_step      = r_in_valid && w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_op    <= i_req.operation;
            r_in_shape <= i_req.shape;
            r_in_x     <= i_req.x_pos;
            r_in_y     <= i_req.y_pos;
            r_in_sx    <= i_req.span_x;
            r_in_sy    <= i_req.span_y;
            r_in_color <= i_req.color;
        end
    end

    // ---------------- clipping ----------------
    function automatic logic signed [CALC_W-1:0] dim_clamp(input logic [CFG_W-1:0] v);
        logic signed [CALC_W-1:0] s;
        s = signed'(CALC_W'(v));
        if (v == '0) begin
            return CALC_W'(1);
        end else if (s > CALC_W'(MAX_DIM)) begin
            return CALC_W'(MAX_DIM);
        end
        return s;
    endfunction

    logic signed [CALC_W-1:0] w_w, w_h, w_x, w_y, w_sx, w_sy;
    logic signed [CALC_W-1:0] w_x_end, w_yl_end, w_y_end;
    logic signed [CALC_W-1:0] w_xs, w_xe, w_ys, w_ye, w_cols, w_rows;
    logic                     w_hit;

    always_comb begin
        w_w      = dim_clamp(r_screen_w);
        w_h      = dim_clamp(r_screen_h);
        w_x      = CALC_W'(r_in_x);
        w_y      = CALC_W'(r_in_y);
        w_sx     = CALC_W'(r_in_sx);
        w_sy     = CALC_W'(r_in_sy);
        w_x_end  = w_x + w_sx - CALC_W'(1);
        w_yl_end = w_y + w_sx - CALC_W'(1);
        w_y_end  = w_y + w_sy - CALC_W'(1);

        w_hit  = 1'b0;
        w_xs   = '0;
        w_xe   = '0;
        w_ys   = '0;
        w_ye   = '0;
        w_cols = CALC_W'(1);
        w_rows = CALC_W'(1);
        case (r_in_shape)
            SHAPE_PIXEL: begin
                w_hit = (w_x >= 0) && (w_y >= 0) && (w_x < w_w) && (w_y < w_h);
                w_xs  = w_x;
                w_ys  = w_y;
                w_xe  = w_w - CALC_W'(1);
                w_ye  = w_h - CALC_W'(1);
            end
            SHAPE_HLINE: begin
                w_hit  = (w_sx > 0) && (w_y >= 0) && (w_y < w_h) && (w_x < w_w)
                         && (w_x_end >= 0);
                w_xs   = (w_x > 0) ? w_x : '0;
                w_xe   = (w_x_end < w_w) ? w_x_end : w_w - CALC_W'(1);
                w_ys   = w_y;
                w_ye   = w_y;
                w_cols = w_xe - w_xs + CALC_W'(1);
            end
            SHAPE_VLINE: begin
                w_hit  = (w_sx > 0) && (w_x >= 0) && (w_x < w_w) && (w_y < w_h)
                         && (w_yl_end >= 0);
                w_ys   = (w_y > 0) ? w_y : '0;
                w_ye   = (w_yl_end < w_h) ? w_yl_end : w_h - CALC_W'(1);
                w_xs   = w_x;
                w_xe   = w_x;
                w_rows = w_ye - w_ys + CALC_W'(1);
            end
            SHAPE_RECT: begin
                w_hit  = (w_sx > 0) && (w_sy > 0) && (w_x < w_w) && (w_y < w_h)
                         && (w_x_end >= 0) && (w_y_end >= 0);
                w_xs   = (w_x > 0) ? w_x : '0;
                w_xe   = (w_x_end < w_w) ? w_x_end : w_w - CALC_W'(1);
                w_ys   = (w_y > 0) ? w_y : '0;
                w_ye   = (w_y_end < w_h) ? w_y_end : w_h - CALC_W'(1);
                w_cols = w_xe - w_xs + CALC_W'(1);
                w_rows = w_ye - w_ys + CALC_W'(1);
            end
            SHAPE_FULL: begin
                w_hit  = 1'b1;
                w_xe   = w_w - CALC_W'(1);
                w_ye   = w_h - CALC_W'(1);
                w_cols = w_w;
                w_rows = w_h;
            end
            default: w_hit = 1'b0;
        endcase
    end

    // ---------------- sequencer state ----------------
    logic                r_busy, n_busy;
    t_phase              r_phase, n_phase;
    logic [CW-1:0]       r_xs, r_xe, r_ys, r_ye, n_xs, n_xe, n_ys, n_ye;
    logic [DW-1:0]       r_cols_reload, n_cols_reload;
    logic [DW-1:0]       r_cols_left, n_cols_left;
    logic [DW-1:0]       r_rows_left, n_rows_left;
    logic [COLOR_W-1:0]  r_color, n_color;
    logic                r_low_next, n_low_next;
    logic                w_last_pixel;

    assign w_last_pixel = (r_cols_left == DW'(1)) && (r_rows_left == DW'(1));

    // next state
    always_comb begin
        n_busy        = r_busy;
        n_phase       = r_phase;
        n_xs          = r_xs;
        n_xe          = r_xe;
        n_ys          = r_ys;
        n_ye          = r_ye;
        n_cols_reload = r_cols_reload;
        n_cols_left   = r_cols_left;
        n_rows_left   = r_rows_left;
        n_color       = r_color;
        n_low_next    = r_low_next;
        if (w_step) begin
            if (r_in_op == OP_REQUEST) begin
                if (!r_busy && w_hit) begin
                    n_busy        = 1'b1;
                    n_phase       = PH_CMD_COL;
                    n_xs          = w_xs[CW-1:0];
                    n_xe          = w_xe[CW-1:0];
                    n_ys          = w_ys[CW-1:0];
                    n_ye          = w_ye[CW-1:0];
                    n_cols_reload = w_cols[DW-1:0];
                    n_cols_left   = w_cols[DW-1:0];
                    n_rows_left   = w_rows[DW-1:0];
                    n_color       = r_in_color;
                    n_low_next    = 1'b0;
                end
            end else if (r_busy) begin
                if (r_phase != PH_DATA) begin
                    n_phase = t_phase'(r_phase + 4'd1);
                end else if (!r_low_next) begin
                    n_low_next = 1'b1;
                end else begin
                    n_low_next = 1'b0;
                    if (w_last_pixel) begin
                        n_busy  = 1'b0;
                        n_phase = PH_CMD_COL;
                    end else if (r_cols_left == DW'(1)) begin
                        // wrap to the next row of the window
                        n_cols_left = r_cols_reload;
                        n_rows_left = r_rows_left - DW'(1);
                    end else begin
                        n_cols_left = r_cols_left - DW'(1);
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b0;
            r_phase    <= PH_CMD_COL;
            r_low_next <= 1'b0;
        end else begin
            r_busy     <= n_busy;
            r_phase    <= n_phase;
            r_low_next <= n_low_next;
        end
    end

    always_ff @(posedge i_clk) begin
        r_xs          <= n_xs;
        r_xe          <= n_xe;
        r_ys          <= n_ys;
        r_ye          <= n_ye;
        r_cols_reload <= n_cols_reload;
        r_cols_left   <= n_cols_left;
        r_rows_left   <= n_rows_left;
        r_color       <= n_color;
    end

    // ---------------- result selection ----------------
    logic                 n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [BYTE_W-1:0]    r_out_byte, n_out_byte;
    logic                 r_out_cmd, n_out_cmd;
    logic                 r_out_last, n_out_last;
    logic [15:0]          w_xs16, w_xe16, w_ys16, w_ye16;

    assign w_xs16 = 16'(r_xs);
    assign w_xe16 = 16'(r_xe);
    assign w_ys16 = 16'(r_ys);
    assign w_ye16 = 16'(r_ye);

    always_comb begin
        n_out_valid  = 1'b0;
        n_out_status = ST_BYTE;
        n_out_byte   = '0;
        n_out_cmd    = 1'b0;
        n_out_last   = 1'b0;
        if (r_in_op == OP_REQUEST) begin
            if (r_busy) begin
                n_out_valid  = 1'b1;
                n_out_status = ST_REFUSED;
                n_out_last   = 1'b1;
            end else if (!w_hit) begin
                n_out_valid  = 1'b1;
                n_out_status = ST_CLIPPED;
                n_out_last   = 1'b1;
            end
        end else if (r_busy) begin
            n_out_valid = 1'b1;
            case (r_phase)
                PH_CMD_COL:   begin n_out_byte = CMD_COLUMN; n_out_cmd = 1'b1; end
                PH_XS_HI:     n_out_byte = w_xs16[15:8];
                PH_XS_LO:     n_out_byte = w_xs16[7:0];
                PH_XE_HI:     n_out_byte = w_xe16[15:8];
                PH_XE_LO:     n_out_byte = w_xe16[7:0];
                PH_CMD_PAGE:  begin n_out_byte = CMD_PAGE; n_out_cmd = 1'b1; end
                PH_YS_HI:     n_out_byte = w_ys16[15:8];
                PH_YS_LO:     n_out_byte = w_ys16[7:0];
                PH_YE_HI:     n_out_byte = w_ye16[15:8];
                PH_YE_LO:     n_out_byte = w_ye16[7:0];
                PH_CMD_WRITE: begin n_out_byte = CMD_WRITE; n_out_cmd = 1'b1; end
                PH_DATA: begin
                    n_out_byte = r_low_next ? r_color[7:0] : r_color[15:8];
                    n_out_last = r_low_next && w_last_pixel;
                end
                default: n_out_byte = '0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_step && n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_status <= n_out_status;
            r_out_byte   <= n_out_byte;
            r_out_cmd    <= n_out_cmd;
            r_out_last   <= n_out_last;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.bus_byte   = r_out_byte;
    assign o_rsp.is_command = r_out_cmd;
    assign o_rsp.last       = r_out_last;

    // ---------------- assertions ----------------
    a_status_only_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && (r_out_status != ST_BYTE)
        |-> r_out_last && !r_out_cmd && (r_out_byte == '0))
        else $error("status-only result carries byte fields");

    a_idle_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_busy |-> (r_phase == PH_CMD_COL) && !r_low_next)
        else $error("sequencer idle with stale phase");

    a_counts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cols_left != '0) && (r_rows_left != '0))
        else $error("busy with empty pixel count");

    a_done_drops_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && (r_in_op == OP_TICK) && r_busy && (r_phase == PH_DATA)
        && r_low_next && w_last_pixel |=> !r_busy && r_out_valid && r_out_last)
        else $error("final pixel did not end the sequence");

    a_low_only_in_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_low_next |-> r_busy && (r_phase == PH_DATA))
        else $error("low byte pending outside data phase");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench for lcd_clipped_fill_sequencer_core: clip requests and LCD bus
// byte sequences are predicted per accepted transaction and compared against the result port.
// Depends on lcs_pkg, lcs_req_if, lcs_rsp_if and the core.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import lcs_pkg::*;

    localparam int CLK_PERIOD      = 20;
    localparam int MAX_SEQ_PIXELS  = 64;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int REPORT_LIMIT    = 10;
    localparam int PHASE_ITEMS     = 50;
    localparam int NUM_PHASES      = 9;

    typedef struct {
        t_op                     op;
        logic [SHAPE_W-1:0]      shape;
        logic signed [POS_W-1:0] x_pos;
        logic signed [POS_W-1:0] y_pos;
        logic signed [POS_W-1:0] span_x;
        logic signed [POS_W-1:0] span_y;
        logic [COLOR_W-1:0]      color;
    } t_draw_item;

    typedef struct {
        logic [9:0] xs;
        logic [9:0] xe;
        logic [9:0] ys;
        logic [9:0] ye;
        int         count;
    } t_fill_window;

    typedef struct {
        t_status           status;
        logic [BYTE_W-1:0] bus_byte;
        logic              is_command;
        logic              last;
    } t_lcd_byte;

    typedef struct {
        bit                 busy;
        t_phase             phase;
        t_fill_window       win;
        int                 pixels_left;
        logic [COLOR_W-1:0] color;
        bit                 low_next;
    } t_fill_seq;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    lcs_req_if req_ch();
    lcs_rsp_if rsp_ch();

    logic [CFG_W-1:0] scr_w;
    logic [CFG_W-1:0] scr_h;
    t_fill_seq        fill_seq;
    t_draw_item       draw_queue[$];
    t_lcd_byte        expected_bytes[$];
    t_draw_item       item_on_bus;
    t_lcd_byte        want;

    int  mismatches;
    int  snd_idle_pct;
    int  rsp_idle_pct;
    int  hold_left;
    logic hold_kick;
    int  quiet_cycles;

    lcd_clipped_fill_sequencer_core DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    function automatic int clamp_dim(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > DEF_MAX_DIM) return DEF_MAX_DIM;
        return int'(v);
    endfunction

    // Clip a draw request to the current screen; returns 1 when something is visible.
    function automatic bit clip_to_screen(input t_draw_item it, output t_fill_window win);
        int w, h, x, y, sx, sy, xs, xe, ys, ye, cnt;
        bit vis;
        w = clamp_dim(scr_w);
        h = clamp_dim(scr_h);
        x = int'(it.x_pos);
        y = int'(it.y_pos);
        sx = int'(it.span_x);
        sy = int'(it.span_y);
        xs = 0; xe = 0; ys = 0; ye = 0; cnt = 0;
        vis = 1'b1;
        case (it.shape)
            SHAPE_PIXEL: begin
                vis = x >= 0 && y >= 0 && x < w && y < h;
                xs = x; ys = y; xe = w - 1; ye = h - 1; cnt = 1;
            end
            SHAPE_HLINE: begin
                vis = !(sx <= 0 || y < 0 || y >= h || x >= w || x + sx - 1 < 0);
                xs = (x > 0) ? x : 0;
                xe = (x + sx - 1 < w - 1) ? x + sx - 1 : w - 1;
                ys = y; ye = y;
                cnt = xe - xs + 1;
            end
            SHAPE_VLINE: begin
                vis = !(sx <= 0 || x < 0 || x >= w || y >= h || y + sx - 1 < 0);
                ys = (y > 0) ? y : 0;
                ye = (y + sx - 1 < h - 1) ? y + sx - 1 : h - 1;
                xs = x; xe = x;
                cnt = ye - ys + 1;
            end
            SHAPE_RECT: begin
                vis = !(sx <= 0 || sy <= 0 || x >= w || y >= h ||
                        x + sx - 1 < 0 || y + sy - 1 < 0);
                xs = (x > 0) ? x : 0;
                xe = (x + sx - 1 < w - 1) ? x + sx - 1 : w - 1;
                ys = (y > 0) ? y : 0;
                ye = (y + sy - 1 < h - 1) ? y + sy - 1 : h - 1;
                cnt = (xe - xs + 1) * (ye - ys + 1);
            end
            SHAPE_FULL: begin
                xe = w - 1; ye = h - 1; cnt = w * h;
            end
            default: vis = 1'b0;
        endcase
        win.xs = 10'(xs);
        win.xe = 10'(xe);
        win.ys = 10'(ys);
        win.ye = 10'(ye);
        win.count = cnt;
        return vis;
    endfunction

    // Advance the sequencer state by one accepted transaction and queue its result.
    task automatic predict_lcd_bytes(input t_draw_item it);
        t_fill_window win;
        t_lcd_byte r;
        bit emit;
        emit = 1'b0;
        r.status = ST_BYTE;
        r.bus_byte = '0;
        r.is_command = 1'b0;
        r.last = 1'b0;
        if (it.op == OP_REQUEST) begin
            if (fill_seq.busy) begin
                r.status = ST_REFUSED;
                r.last = 1'b1;
                emit = 1'b1;
            end else if (!clip_to_screen(it, win)) begin
                r.status = ST_CLIPPED;
                r.last = 1'b1;
                emit = 1'b1;
            end else begin
                fill_seq.win = win;
                fill_seq.pixels_left = win.count;
                fill_seq.color = it.color;
                fill_seq.low_next = 1'b0;
                fill_seq.phase = PH_CMD_COL;
                fill_seq.busy = 1'b1;
            end
        end else if (fill_seq.busy) begin
            emit = 1'b1;
            case (fill_seq.phase)
                PH_CMD_COL: begin
                    r.bus_byte = CMD_COLUMN;
                    r.is_command = 1'b1;
                end
                PH_XS_HI: r.bus_byte = {6'd0, fill_seq.win.xs[9:8]};
                PH_XS_LO: r.bus_byte = fill_seq.win.xs[7:0];
                PH_XE_HI: r.bus_byte = {6'd0, fill_seq.win.xe[9:8]};
                PH_XE_LO: r.bus_byte = fill_seq.win.xe[7:0];
                PH_CMD_PAGE: begin
                    r.bus_byte = CMD_PAGE;
                    r.is_command = 1'b1;
                end
                PH_YS_HI: r.bus_byte = {6'd0, fill_seq.win.ys[9:8]};
                PH_YS_LO: r.bus_byte = fill_seq.win.ys[7:0];
                PH_YE_HI: r.bus_byte = {6'd0, fill_seq.win.ye[9:8]};
                PH_YE_LO: r.bus_byte = fill_seq.win.ye[7:0];
                PH_CMD_WRITE: begin
                    r.bus_byte = CMD_WRITE;
                    r.is_command = 1'b1;
                end
                default: begin
                    if (!fill_seq.low_next) begin
                        r.bus_byte = fill_seq.color[15:8];
                        fill_seq.low_next = 1'b1;
                    end else begin
                        r.bus_byte = fill_seq.color[7:0];
                        fill_seq.low_next = 1'b0;
                        if (fill_seq.pixels_left <= 1) begin
                            fill_seq.pixels_left = 0;
                            r.last = 1'b1;
                            fill_seq.busy = 1'b0;
                            fill_seq.phase = PH_CMD_COL;
                        end else begin
                            fill_seq.pixels_left--;
                        end
                    end
                end
            endcase
            if (fill_seq.busy && fill_seq.phase != PH_DATA)
                fill_seq.phase = t_phase'(fill_seq.phase + 1);
        end
        if (emit) expected_bytes.push_back(r);
    endtask

    function automatic t_draw_item make_draw(input logic [SHAPE_W-1:0] shape, input int x,
                                             input int y, input int sx, input int sy,
                                             input logic [COLOR_W-1:0] color);
        t_draw_item it;
        it.op = OP_REQUEST;
        it.shape = shape;
        it.x_pos = 16'(x);
        it.y_pos = 16'(y);
        it.span_x = 16'(sx);
        it.span_y = 16'(sy);
        it.color = color;
        return it;
    endfunction

    // Tick payload is don't-care; randomize it to show it is ignored.
    function automatic t_draw_item make_tick();
        t_draw_item it;
        it = make_draw(SHAPE_W'($urandom_range(7, 0)), $urandom, $urandom, $urandom,
                       $urandom, COLOR_W'($urandom));
        it.op = OP_TICK;
        return it;
    endfunction

    function automatic t_draw_item make_noise();
        return make_draw(SHAPE_W'($urandom_range(7, 0)), $urandom, $urandom, $urandom,
                         $urandom, COLOR_W'($urandom));
    endfunction

    function automatic int near_edge(input int d);
        case ($urandom_range(3, 0))
            0: return int'($urandom_range(6, 0)) - 3;
            1: return d - 4 + int'($urandom_range(6, 0));
            2: return int'($urandom_range(d - 1, 0));
            default: return int'($signed(16'($urandom)));
        endcase
    endfunction

    function automatic int pick_span(input int d);
        case ($urandom_range(7, 0))
            0: return -int'($urandom_range(2, 0));
            1: return 32767;
            2: return int'($signed(16'($urandom)));
            default: return int'($urandom_range((d < 8) ? d + 4 : 12, 1));
        endcase
    endfunction

    function automatic t_draw_item make_shaped();
        int w, h;
        logic [SHAPE_W-1:0] shape;
        shape = SHAPE_W'($urandom_range(SHAPE_FULL, SHAPE_PIXEL));
        w = clamp_dim(scr_w);
        h = clamp_dim(scr_h);
        return make_draw(shape, near_edge(w), near_edge(h),
                         pick_span((shape == SHAPE_VLINE) ? h : w), pick_span(h),
                         COLOR_W'($urandom));
    endfunction

    // Reroll requests whose fill would be too long to drain cheaply.
    function automatic t_draw_item pick_request(input bit well_formed);
        t_draw_item it;
        t_fill_window win;
        for (int k = 0; k < 20; k++) begin
            if (well_formed) it = make_shaped();
            else it = make_noise();
            if (!clip_to_screen(it, win) || win.count <= MAX_SEQ_PIXELS) return it;
        end
        return make_draw(SHAPE_PIXEL, 0, 0, 0, 0, COLOR_W'($urandom));
    endfunction

    // Queue a request and, if visible, the ticks that drain its whole byte sequence,
    // with refused requests mixed in while the fill runs.
    task automatic emit_sequence(input t_draw_item it, input int refuse_pct, inout int n);
        t_fill_window win;
        draw_queue.push_back(it);
        n++;
        if (it.op == OP_REQUEST && clip_to_screen(it, win)) begin
            repeat (11 + 2 * win.count) begin
                if ($urandom_range(99, 0) < refuse_pct) begin
                    draw_queue.push_back(make_noise());
                    n++;
                end
                draw_queue.push_back(make_tick());
                n++;
            end
        end
    endtask

    task automatic write_screen_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_SCREEN_WIDTH) scr_w = value;
        else scr_h = value;
    endtask

    task automatic drain();
        while (draw_queue.size() != 0 || req_ch.valid || expected_bytes.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input logic [CFG_W-1:0] w, input logic [CFG_W-1:0] h,
                             input bit squeeze);
        int n, roll;
        write_screen_reg(CFG_SCREEN_WIDTH, w);
        write_screen_reg(CFG_SCREEN_HEIGHT, h);
        n = 0;
        while (n < PHASE_ITEMS) begin
            roll = $urandom_range(99, 0);
            if (roll < 8) draw_queue.push_back(make_tick());
            else emit_sequence(pick_request(roll < 80), 15, n);
        end
        if (squeeze) begin
            hold_kick <= 1'b1;
            @(posedge i_clk);
            hold_kick <= 1'b0;
        end
        drain();
    endtask

    task automatic flag_mismatch(input string what, input t_lcd_byte exp_r);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
            $display("%t %s: expected st=%0d byte=%02h cmd=%0b last=%0b",
                     $realtime, what, exp_r.status, exp_r.bus_byte, exp_r.is_command,
                     exp_r.last);
            $display("    got st=%0d byte=%02h cmd=%0b last=%0b",
                     rsp_ch.status, rsp_ch.bus_byte, rsp_ch.is_command, rsp_ch.last);
        end
    endtask

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Request driver: predict at acceptance, then offer the next queued item.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
        end else begin
            if (req_ch.valid && req_ch.ready) predict_lcd_bytes(item_on_bus);
            if (!req_ch.valid || req_ch.ready) begin
                if (draw_queue.size() != 0 && $urandom_range(99, 0) >= snd_idle_pct) begin
                    item_on_bus = draw_queue.pop_front();
                    req_ch.operation <= item_on_bus.op;
                    req_ch.shape     <= item_on_bus.shape;
                    req_ch.x_pos     <= item_on_bus.x_pos;
                    req_ch.y_pos     <= item_on_bus.y_pos;
                    req_ch.span_x    <= item_on_bus.span_x;
                    req_ch.span_y    <= item_on_bus.span_y;
                    req_ch.color     <= item_on_bus.color;
                    req_ch.valid     <= 1'b1;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, then drive ready.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                if (expected_bytes.size() == 0) begin
                    want.status = ST_BYTE;
                    want.bus_byte = '0;
                    want.is_command = 1'b0;
                    want.last = 1'b0;
                    flag_mismatch("unexpected result", want);
                end else begin
                    want = expected_bytes.pop_front();
                    if (rsp_ch.status !== want.status || rsp_ch.bus_byte !== want.bus_byte ||
                        rsp_ch.is_command !== want.is_command || rsp_ch.last !== want.last)
                        flag_mismatch("result mismatch", want);
                end
            end
            rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99, 0) >= rsp_idle_pct);
        end
    end

    // Long receiver hold-off so the core backs up and stalls its input.
    always @(posedge i_clk) begin
        if (!i_rst_n) hold_left <= 0;
        else if (hold_kick) hold_left <= HOLD_CYCLES;
        else if (hold_left != 0) hold_left <= hold_left - 1;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("lcd_clipped_fill_sequencer_core regression: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        logic [CFG_W-1:0] phase_w[NUM_PHASES];
        logic [CFG_W-1:0] phase_h[NUM_PHASES];
        phase_w = '{11'd5, 11'd0, 11'd2047, 11'd1, 11'd16, 11'd1024, 11'd7, 11'd320, 11'd3};
        phase_h = '{11'd4, 11'd0, 11'd3, 11'd2047, 11'd16, 11'd1024, 11'd9, 11'd480, 11'd12};
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_SCREEN_WIDTH;
        i_cfg_data = '0;
        req_ch.valid = 1'b0;
        req_ch.operation = OP_TICK;
        req_ch.shape = '0;
        req_ch.x_pos = '0;
        req_ch.y_pos = '0;
        req_ch.span_x = '0;
        req_ch.span_y = '0;
        req_ch.color = '0;
        rsp_ch.ready = 1'b0;
        hold_kick = 1'b0;
        quiet_cycles = 0;
        mismatches = 0;
        snd_idle_pct = 11;
        rsp_idle_pct = 72;
        scr_w = SCREEN_W_RESET;
        scr_h = SCREEN_H_RESET;
        fill_seq.busy = 1'b0;
        fill_seq.phase = PH_CMD_COL;
        fill_seq.low_next = 1'b0;
        fill_seq.pixels_left = 0;
        n = 0;

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Small screen: edges, every shape, clipping, refusal, idle tick.
        write_screen_reg(CFG_SCREEN_WIDTH, 11'd8);
        write_screen_reg(CFG_SCREEN_HEIGHT, 11'd6);
        draw_queue.push_back(make_tick());
        emit_sequence(make_draw(SHAPE_PIXEL, 0, 0, 0, 0, 16'hFFFF), 0, n);
        emit_sequence(make_draw(SHAPE_PIXEL, 7, 5, 0, 0, 16'h0000), 50, n);
        emit_sequence(make_draw(SHAPE_PIXEL, 8, 0, 0, 0, 16'h1111), 0, n);
        emit_sequence(make_draw(SHAPE_PIXEL, -1, 0, 0, 0, 16'h2222), 0, n);
        emit_sequence(make_draw(SHAPE_PIXEL, 0, 6, 0, 0, 16'h3333), 0, n);
        emit_sequence(make_draw(SHAPE_PIXEL, 0, -32768, 0, 0, 16'h4444), 0, n);
        emit_sequence(make_draw(SHAPE_HLINE, -3, 2, 5, 0, 16'h1234), 0, n);
        emit_sequence(make_draw(SHAPE_HLINE, 0, 0, 0, 0, 16'h5555), 0, n);
        emit_sequence(make_draw(SHAPE_HLINE, 0, 0, -32768, 0, 16'h6666), 0, n);
        emit_sequence(make_draw(SHAPE_VLINE, 7, 4, 32767, 0, 16'hA5C3), 0, n);
        emit_sequence(make_draw(SHAPE_VLINE, 8, 0, 3, 0, 16'h7777), 0, n);
        emit_sequence(make_draw(SHAPE_RECT, -32768, 0, 32767, 2, 16'h8888), 0, n);
        emit_sequence(make_draw(SHAPE_RECT, 32767, 32767, 32767, 32767, 16'h9999), 0, n);
        emit_sequence(make_draw(SHAPE_RECT, -2, -2, 32767, 32767, 16'h5AA5), 0, n);
        emit_sequence(make_draw(SHAPE_RECT, 1, 1, 3, 0, 16'hBBBB), 0, n);
        emit_sequence(make_draw(SHAPE_FULL, 0, 0, 0, 0, 16'h0F0F), 0, n);
        for (int s = int'(SHAPE_FULL) + 1; s < (1 << SHAPE_W); s++)
            emit_sequence(make_draw(SHAPE_W'(s), 0, 0, 1, 1, 16'hCCCC), 0, n);
        drain();

        // Oversized registers clamp to the largest screen: window high bytes.
        write_screen_reg(CFG_SCREEN_WIDTH, 11'd2047);
        write_screen_reg(CFG_SCREEN_HEIGHT, 11'd1025);
        emit_sequence(make_draw(SHAPE_PIXEL, 1023, 1023, 0, 0, 16'hF00D), 0, n);
        emit_sequence(make_draw(SHAPE_HLINE, 1020, 512, 32767, 0, 16'hBEEF), 0, n);
        emit_sequence(make_draw(SHAPE_RECT, -5, 1020, 8, 100, 16'h7E57), 0, n);
        drain();

        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 3) begin
                snd_idle_pct <= 72;
                rsp_idle_pct <= 11;
            end else if (p == 6) begin
                snd_idle_pct <= 0;
                rsp_idle_pct <= 0;
            end
            run_phase(phase_w[p], phase_h[p], p == 6);
        end

        drain();
        if (mismatches == 0) begin
            $display("lcd_clipped_fill_sequencer_core regression: pass");
        end else begin
            $display("lcd_clipped_fill_sequencer_core regression: fail");
        end
        $finish;
    end
endmodule
